[rtl/core/dwa_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dwa_pkg: shared types and codes for the deadline waitlist arbiter
// Operation kinds, result status codes and the structs that run along the
// cell chain.
// ----------------------------------------------------------------------------
package dwa_pkg;

    localparam logic [1:0] KIND_ENQ = 2'd0;
    localparam logic [1:0] KIND_DEQ = 2'd1;
    localparam logic [1:0] KIND_QRY = 2'd2;

    localparam logic [1:0] STATUS_OK      = 2'd0;
    localparam logic [1:0] STATUS_FULL    = 2'd1;
    localparam logic [1:0] STATUS_MISSING = 2'd2;

    localparam logic REG_MODE     = 1'b0;
    localparam logic REG_COOLDOWN = 1'b1;

    // Carried from cell to cell: first id match seen so far, and whether
    // any earlier cell holds a waiter that precedes the requester.
    typedef struct packed {
        logic found;
        logic block;
    } chain_t;

    // Broadcast to every cell for the operation being executed.
    typedef struct packed {
        logic enq;
        logic deq;
        logic mode;
    } cell_ctrl_t;

endpackage

[rtl/core/deadline_waitlist_arbiter.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// deadline_waitlist_arbiter: EDF / FIFO waitlist for one shared resource
// Keeps a compacted list of waiters in a chain of cells and answers enqueue,
// dequeue and grant queries, one result transfer per request transfer.
// ----------------------------------------------------------------------------
// Usage:
//   Requests enter on the s_* stream; tuser carries the operation kind
//   (enqueue, dequeue, query). Each request yields exactly one result on the
//   m_* stream: grant flag and waiter count in tdata, status in tuser.
//   A request is first captured in the request registers and then executed:
//   all cells compare in parallel, the match and precedence flags ripple
//   along the chain, the cells shift or load, and the result is loaded into
//   the output register. A new request is accepted only once the current one
//   has executed. If the output register still holds an untaken result,
//   execution waits and s_tready stays low until the result is taken.
//   Reset empties the list, sets FIFO ordering and a zero cooldown.
//   Registers (APB): 0x0 deadline_mode, 0x4 cooldown_time; write only while
//   idle.
// ----------------------------------------------------------------------------
module deadline_waitlist_arbiter
    import dwa_pkg::*;
#(
    parameter int MAX_WAITERS = 16,
    parameter int KEY_BITS    = 32
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    // [7:0] requester_id, [39:8] requester_deadline, [71:40] requester_ticket,
    // [103:72] now_time, [135:104] release_time, [136] resource_locked
    input  logic [143:0] s_tdata,
    // [1:0] kind
    input  logic [1:0]   s_tuser,
    output logic         m_tvalid,
    input  logic         m_tready,
    // [0] turn_granted, [5:1] waiter_count
    output logic [7:0]   m_tdata,
    // [1:0] status
    output logic [1:0]   m_tuser,
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [2:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready
);

    localparam int CNT_W = $clog2(MAX_WAITERS + 1);

    // configuration
    logic        mode_reg;
    logic [31:0] cooldown_reg;

    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_COOLDOWN) ? cooldown_reg : {31'd0, mode_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg     <= 1'b0;
            cooldown_reg <= 32'd0;
        end
        else if (psel && penable && pwrite && pready)
        begin
            if (paddr[2] == REG_MODE)
                mode_reg <= pwdata[0];
            else
                cooldown_reg <= pwdata;
        end
    end

    // request capture
    logic                busy_reg;
    logic [1:0]          kind_reg;
    logic [7:0]          item_id_reg;
    logic [KEY_BITS-1:0] item_dl_reg;
    logic [KEY_BITS-1:0] item_tk_reg;
    logic                time_ok_reg;
    logic [KEY_BITS-1:0] in_dl_key;
    logic [KEY_BITS-1:0] in_tk_key;
    logic [31:0]         elapsed;
    logic                accept;
    logic                commit;
    logic                m_tvalid_reg;

    generate
        if (KEY_BITS > 32)
        begin : g_key_wide
            assign in_dl_key = {{(KEY_BITS-32){1'b0}}, s_tdata[39:8]};
            assign in_tk_key = {{(KEY_BITS-32){1'b0}}, s_tdata[71:40]};
        end
        else if (KEY_BITS == 32)
        begin : g_key_full
            assign in_dl_key = s_tdata[39:8];
            assign in_tk_key = s_tdata[71:40];
        end
        else
        begin : g_key_narrow
            assign in_dl_key = s_tdata[8 +: KEY_BITS];
            assign in_tk_key = s_tdata[40 +: KEY_BITS];
        end
    endgenerate

    assign elapsed  = s_tdata[103:72] - s_tdata[135:104];
    assign s_tready = !busy_reg;
    assign accept   = s_tvalid && s_tready;
    assign commit   = busy_reg && (!m_tvalid_reg || m_tready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            busy_reg <= 1'b0;
        else if (accept)
            busy_reg <= 1'b1;
        else if (commit)
            busy_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            kind_reg    <= s_tuser;
            item_id_reg <= s_tdata[7:0];
            item_dl_reg <= in_dl_key;
            item_tk_reg <= in_tk_key;
            time_ok_reg <= !s_tdata[136] && (elapsed >= cooldown_reg);
        end
    end

    // cell chain
    logic [CNT_W-1:0]    cnt_reg, cnt_next;
    logic                full;
    cell_ctrl_t          ctrl;
    chain_t              chain [MAX_WAITERS+1];
    logic [7:0]          cell_id [MAX_WAITERS];
    logic [KEY_BITS-1:0] cell_dl [MAX_WAITERS];
    logic [KEY_BITS-1:0] cell_tk [MAX_WAITERS];

    assign full      = (cnt_reg == CNT_W'(MAX_WAITERS));
    assign ctrl.mode = mode_reg;
    assign ctrl.enq  = commit && (kind_reg == KIND_ENQ) && !full;
    assign ctrl.deq  = commit && (kind_reg == KIND_DEQ) && chain[MAX_WAITERS].found;
    assign chain[0]  = '0;

    generate
        for (genvar i = 0; i < MAX_WAITERS; i++)
        begin : g_cell
            logic [7:0]          nb_id;
            logic [KEY_BITS-1:0] nb_dl;
            logic [KEY_BITS-1:0] nb_tk;

            if (i + 1 < MAX_WAITERS)
            begin : g_nb
                assign nb_id = cell_id[i+1];
                assign nb_dl = cell_dl[i+1];
                assign nb_tk = cell_tk[i+1];
            end
            else
            begin : g_top
                // nothing above the last slot; its content becomes unused
                assign nb_id = cell_id[i];
                assign nb_dl = cell_dl[i];
                assign nb_tk = cell_tk[i];
            end

            dwa_cell #(
                .KEY_BITS (KEY_BITS)
            ) u_cell (
                .clk       (clk),
                .ctrl      (ctrl),
                .active    (cnt_reg > CNT_W'(i)),
                .tail      (cnt_reg == CNT_W'(i)),
                .item_id   (item_id_reg),
                .item_dl   (item_dl_reg),
                .item_tk   (item_tk_reg),
                .nb_id     (nb_id),
                .nb_dl     (nb_dl),
                .nb_tk     (nb_tk),
                .id        (cell_id[i]),
                .dl        (cell_dl[i]),
                .tk        (cell_tk[i]),
                .chain_in  (chain[i]),
                .chain_out (chain[i+1])
            );
        end
    endgenerate

    always_comb
    begin
        cnt_next = cnt_reg;
        if (ctrl.enq)
            cnt_next = cnt_reg + CNT_W'(1);
        else if (ctrl.deq)
            cnt_next = cnt_reg - CNT_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cnt_reg <= '0;
        else
            cnt_reg <= cnt_next;
    end

    // result
    logic             grant;
    logic [1:0]       status;
    logic [CNT_W+4:0] cnt_wide;
    logic             grant_reg;
    logic [1:0]       status_reg;
    logic [4:0]       count_reg;

    assign grant    = (kind_reg == KIND_QRY) && time_ok_reg && !chain[MAX_WAITERS].block;
    assign cnt_wide = {5'd0, cnt_next};

    always_comb
    begin
        case (kind_reg)
            KIND_ENQ: status = full ? STATUS_FULL : STATUS_OK;
            KIND_DEQ: status = chain[MAX_WAITERS].found ? STATUS_OK : STATUS_MISSING;
            default:  status = STATUS_OK;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_tvalid_reg <= 1'b0;
        else if (commit)
            m_tvalid_reg <= 1'b1;
        else if (m_tready)
            m_tvalid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (commit)
        begin
            grant_reg  <= grant;
            status_reg <= status;
            count_reg  <= cnt_wide[4:0];
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {2'd0, count_reg, grant_reg};
    assign m_tuser  = status_reg;

endmodule

[rtl/core/dwa_cell.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dwa_cell: one waitlist slot
// Holds one waiter's id and keys, compares them against the current item, loads the item at
// the tail on enqueue and takes its upper neighbor's entry when a dequeue closes a gap at or below it.
// ----------------------------------------------------------------------------
module dwa_cell
    import dwa_pkg::*;
#(
    parameter int KEY_BITS = 32
) (
    input  logic                clk,
    input  cell_ctrl_t          ctrl,
    input  logic                active,
    input  logic                tail,
    input  logic [7:0]          item_id,
    input  logic [KEY_BITS-1:0] item_dl,
    input  logic [KEY_BITS-1:0] item_tk,
    input  logic [7:0]          nb_id,
    input  logic [KEY_BITS-1:0] nb_dl,
    input  logic [KEY_BITS-1:0] nb_tk,
    output logic [7:0]          id,
    output logic [KEY_BITS-1:0] dl,
    output logic [KEY_BITS-1:0] tk,
    input  chain_t              chain_in,
    output chain_t              chain_out
);

    logic [7:0]          id_reg, id_next;
    logic [KEY_BITS-1:0] dl_reg, dl_next;
    logic [KEY_BITS-1:0] tk_reg, tk_next;
    logic                match;
    logic                precede;
    logic                shift;

    assign match   = active && (id_reg == item_id);
    assign precede = ctrl.mode ? (dl_reg < item_dl) : (tk_reg < item_tk);

    assign chain_out.found = chain_in.found || match;
    assign chain_out.block = chain_in.block || (active && !match && precede);

    // at or above the first match: pull the entry down from above
    assign shift = ctrl.deq && (chain_in.found || match);

    always_comb
    begin
        id_next = id_reg;
        dl_next = dl_reg;
        tk_next = tk_reg;
        if (ctrl.enq && tail)
        begin
            id_next = item_id;
            dl_next = item_dl;
            tk_next = item_tk;
        end
        else if (shift)
        begin
            id_next = nb_id;
            dl_next = nb_dl;
            tk_next = nb_tk;
        end
    end

    always_ff @(posedge clk)
    begin
        id_reg <= id_next;
        dl_reg <= dl_next;
        tk_reg <= tk_next;
    end

    assign id = id_reg;
    assign dl = dl_reg;
    assign tk = tk_reg;

endmodule
